// ===== src/sfpt_pkg.sv =====
package sfpt_pkg;

    localparam int COEF_W  = 32;
    localparam int TOL_W   = 16;
    localparam int PROD_W  = 2 * COEF_W;
    // offset term d - r - slack, one guard bit for each subtraction
    localparam int OFS_W   = COEF_W + 2;
    localparam int FRAC_W  = 16;
    // three products plus the shifted offset term, kept exact
    localparam int ACC_W   = PROD_W + 4;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;

    typedef enum logic [1:0] {
        MODE_LOAD   = 2'd0,
        MODE_STRICT = 2'd1,
        MODE_TOL    = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SEL_X = 2'd0,
        SEL_Y = 2'd1,
        SEL_Z = 2'd2,
        SEL_W = 2'd3
    } coef_sel_t;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_SUM  = 6'b001000,
        ST_CHK  = 6'b010000,
        ST_RESP = 6'b100000
    } state_t;

    typedef struct packed {
        logic      load_en;   // write the request's plane row
        logic      start;     // capture sphere and slack
        logic      rd_en;     // fetch plane row
        logic      mul_en;    // one product through the multiplier
        coef_sel_t mul_sel;
        logic      init_acc;  // seed accumulator with offset term
        logic      acc_add;   // fold product register into accumulator
        logic      res_load;  // load result register
        logic      res_val;
    } cmd_t;

    typedef struct packed {
        logic beyond;         // accumulator strictly positive
    } sts_t;

endpackage

// ===== src/sfpt_if.sv =====
interface sfpt_in_if;
    import sfpt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic [2:0]               plane_index;
    logic signed [COEF_W-1:0] coef_x;
    logic signed [COEF_W-1:0] coef_y;
    logic signed [COEF_W-1:0] coef_z;
    logic signed [COEF_W-1:0] coef_w;

    modport source (
        output valid, mode, plane_index, coef_x, coef_y, coef_z, coef_w,
        input  ready
    );

    modport sink (
        input  valid, mode, plane_index, coef_x, coef_y, coef_z, coef_w,
        output ready
    );
endinterface

interface sfpt_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (
        output valid, inside_res,
        input  ready
    );

    modport sink (
        input  valid, inside_res,
        output ready
    );
endinterface

// ===== src/sfpt_dp.sv =====
module sfpt_dp
    import sfpt_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int PIDX_W     = 3
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [PIDX_W-1:0]        rd_addr,
    input  logic [1:0]               mode,
    input  logic [2:0]               plane_index,
    input  logic signed [COEF_W-1:0] coef_x,
    input  logic signed [COEF_W-1:0] coef_y,
    input  logic signed [COEF_W-1:0] coef_z,
    input  logic signed [COEF_W-1:0] coef_w,
    input  logic                     tolerance_we,
    input  logic [TOL_W-1:0]         tolerance_wdata,
    output sts_t                     sts,
    output logic                     inside_res
);

    logic [4*COEF_W-1:0]      plane_mem [NUM_PLANES];
    logic [4*COEF_W-1:0]      row_reg;
    logic [TOL_W-1:0]         tol_reg;
    logic signed [COEF_W-1:0] x_reg;
    logic signed [COEF_W-1:0] y_reg;
    logic signed [COEF_W-1:0] z_reg;
    logic signed [COEF_W-1:0] r_reg;
    logic [TOL_W-1:0]         slack_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     res_reg;

    logic                     idx_ok;
    logic signed [COEF_W-1:0] op_a;
    logic signed [COEF_W-1:0] op_b;
    logic signed [OFS_W-1:0]  ofs;

    assign idx_ok = {1'b0, plane_index} < 4'(NUM_PLANES);

    // plane row: word 0 a, 1 b, 2 c, 3 d
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && idx_ok)
        begin
            plane_mem[plane_index[PIDX_W-1:0]] <= {coef_w, coef_z, coef_y, coef_x};
        end
        if (cmd.rd_en)
        begin
            row_reg <= plane_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (tolerance_we)
        begin
            tol_reg <= tolerance_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg     <= coef_x;
            y_reg     <= coef_y;
            z_reg     <= coef_z;
            r_reg     <= coef_w;
            slack_reg <= (mode == MODE_TOL) ? tol_reg : '0;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            SEL_X:
            begin
                op_a = row_reg[0*COEF_W +: COEF_W];
                op_b = x_reg;
            end
            SEL_Y:
            begin
                op_a = row_reg[1*COEF_W +: COEF_W];
                op_b = y_reg;
            end
            SEL_Z:
            begin
                op_a = row_reg[2*COEF_W +: COEF_W];
                op_b = z_reg;
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // d - r - slack in Q18.16, exact
    assign ofs = OFS_W'($signed(row_reg[3*COEF_W +: COEF_W])) - OFS_W'(r_reg)
               - $signed({{(OFS_W-TOL_W){1'b0}}, slack_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        if (cmd.init_acc)
        begin
            acc_reg <= {{(ACC_W-OFS_W-FRAC_W){ofs[OFS_W-1]}}, ofs, {FRAC_W{1'b0}}};
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.res_load)
        begin
            res_reg <= cmd.res_val;
        end
    end

    assign sts.beyond = !acc_reg[ACC_W-1] && (|acc_reg);
    assign inside_res = res_reg;

endmodule

// ===== src/sfpt_ctrl.sv =====
module sfpt_ctrl
    import sfpt_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int PIDX_W     = 3
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_mode,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    input  sts_t              sts,
    output cmd_t              cmd,
    output logic [PIDX_W-1:0] rd_addr
);

    state_t            state_reg;
    state_t            state_next;
    logic [PIDX_W-1:0] plane_reg;
    logic [PIDX_W-1:0] plane_next;
    logic [1:0]        step_reg;
    logic [1:0]        step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              take;
    logic              is_test;
    logic              last_plane;

    assign take       = req_valid && req_ready;
    assign is_test    = (req_mode == MODE_STRICT) || (req_mode == MODE_TOL);
    assign last_plane = plane_reg == PIDX_W'(NUM_PLANES - 1);
    assign req_ready  = state_reg == ST_IDLE;
    assign rsp_valid  = out_valid_reg;
    assign rd_addr    = plane_reg;

    always_comb
    begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd            = '0;
        cmd.mul_sel    = coef_sel_t'(step_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (req_mode)
                        MODE_LOAD:
                        begin
                            cmd.load_en = 1'b1;
                        end
                        MODE_STRICT, MODE_TOL:
                        begin
                            cmd.start  = 1'b1;
                            plane_next = '0;
                            state_next = ST_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                step_next  = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.init_acc = step_reg == 2'd0;
                cmd.acc_add  = step_reg != 2'd0;
                step_next    = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.acc_add = 1'b1;
                state_next  = ST_CHK;
            end
            ST_CHK:
            begin
                if (sts.beyond || last_plane)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    plane_next = plane_reg + PIDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_RESP:
            begin
                // inside flag reuses the last check: beyond stops the sweep
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_val    = !sts.beyond;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_test_starts: assert property (@(posedge clk) disable iff (!rst_n)
        take && is_test |=> state_reg == ST_RD && plane_reg == '0)
        else $error("test request did not start plane sweep");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |-> step_reg != 2'd3)
        else $error("multiply step out of range");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> plane_reg <= PIDX_W'(NUM_PLANES - 1))
        else $error("plane counter out of range");

    a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> state_reg == ST_IDLE && out_valid_reg)
        else $error("result load did not publish");

    a_chk_path: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SUM |=> state_reg == ST_CHK && $stable(plane_reg))
        else $error("sum did not lead to check");

endmodule

// ===== src/sphere_frustum_plane_test_core.sv =====
// Channel   Dir  Payload                                        Role
// req       in   mode, plane_index, coef_x/y/z/w (Q16.16)       plane load or sphere test
// rsp       out  inside_res                                     one flag per test request
// tolerance in   tolerance_we, tolerance_wdata (16 bit)         slack for tolerance mode
//
// Load request: taken while idle, writes one plane row if the index is in range; no response.
// Test request: planes are examined in turn from plane 0;
//   the single shared 32x32 multiplier forms a*x, b*y, c*z in turn, framed by
//   the row read, the last accumulate and the sign check. The sweep stops at
//   the first plane the sphere lies beyond.
// Output register holds a result while the next request is taken; a test
//   waits in its response step only if the previous result is still unread.
// Reset: control cleared, tolerance set to 66; plane rows are not cleared.
module sphere_frustum_plane_test_core
    import sfpt_pkg::*;
#(
    parameter int NUM_PLANES = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    sfpt_in_if.sink          req,
    sfpt_out_if.source       rsp,
    input  logic             tolerance_we,
    input  logic [TOL_W-1:0] tolerance_wdata
);

    // plane counter width, at least one bit
    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    cmd_t              cmd;
    sts_t              sts;
    logic [PIDX_W-1:0] rd_addr;

    // sequencer: request handshake, plane sweep, response slot
    sfpt_ctrl #(
        .NUM_PLANES (NUM_PLANES),
        .PIDX_W     (PIDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    // plane memory, shared multiplier, exact wide accumulator
    sfpt_dp #(
        .NUM_PLANES (NUM_PLANES),
        .PIDX_W     (PIDX_W)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .mode            (req.mode),
        .plane_index     (req.plane_index),
        .coef_x          (req.coef_x),
        .coef_y          (req.coef_y),
        .coef_z          (req.coef_z),
        .coef_w          (req.coef_w),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata),
        .sts             (sts),
        .inside_res      (rsp.inside_res)
    );

endmodule
